// ===== design/icaf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icaf_pkg
// Types, constants and tables shared by the angle filter modules.
// ----------------------------------------------------------------------------
package icaf_pkg;

    localparam int CordicSteps = 16;
    localparam int StepW       = $clog2(CordicSteps + 1);
    localparam int CW          = 40;   // CORDIC x/y width
    localparam int ZW          = 36;   // CORDIC angle width, Q6.30 radians

    localparam logic [ZW-1:0] PI_Q30 = 36'sd3373259426;
    // radians to degrees: |z| * 9000 / 2572288, with 2572288 = 157 * 2^14
    localparam logic [45:0]   DEG_NUM  = 46'd9000;
    localparam logic [45:0]   DEG_HALF = 46'd1286144;
    // ceil(2^40 / 157) = 2^32 + DEG_RECIP_LO, exact for dividends below 2^32
    localparam logic [31:0]   DEG_RECIP_LO = 32'd2708291480;

    localparam logic [2:0] REG_INTERVAL = 3'd0;
    localparam logic [2:0] REG_WEIGHT   = 3'd1;
    localparam logic [2:0] REG_NORM     = 3'd2;
    localparam logic [2:0] REG_INV_X    = 3'd3;
    localparam logic [2:0] REG_INV_Y    = 3'd4;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pitch_deg;
        logic signed [31:0] roll_deg;
        logic signed [31:0] yaw_deg;
        logic               accel_trusted;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } cfg_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_CORDIC, ST_DEG, ST_DIV, ST_GYRO,
        ST_BLEND_MUL, ST_BLEND, ST_OUT, ST_HOLD
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic cordic_step;
        logic deg;
        logic div_step;
        logic gyro;
        logic blend_mul;
        logic blend;
        logic out;
        logic axis;      // 0: x tilt, 1: y tilt
    } cmd_t;

    typedef struct packed {
        logic cordic_done;
    } status_t;

    function automatic logic [ZW-1:0] atan_tab(input logic [4:0] i);
        logic [ZW-1:0] r;
        begin
            unique case (i)
                5'd0: r = 36'd843314856;   5'd1: r = 36'd497837829;
                5'd2: r = 36'd263043836;   5'd3: r = 36'd133525158;
                5'd4: r = 36'd67021686;    5'd5: r = 36'd33543515;
                5'd6: r = 36'd16775850;    5'd7: r = 36'd8388437;
                5'd8: r = 36'd4194282;     5'd9: r = 36'd2097149;
                5'd10: r = 36'd1048575;    5'd11: r = 36'd524287;
                5'd12: r = 36'd262143;     5'd13: r = 36'd131071;
                5'd14: r = 36'd65535;      5'd15: r = 36'd32767;
                5'd16: r = 36'd16383;      5'd17: r = 36'd8191;
                5'd18: r = 36'd4095;       5'd19: r = 36'd2047;
                5'd20: r = 36'd1023;       5'd21: r = 36'd511;
                5'd22: r = 36'd255;        5'd23: r = 36'd127;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        begin
            if (v > 48'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -48'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/icaf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icaf_ctrl
// Sequencer: runs two CORDIC atan2 passes, degree division, then the update.
// ----------------------------------------------------------------------------
module icaf_ctrl import icaf_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_fire,
    input  wire logic    out_fire,
    input  wire status_t stat,
    output cmd_t         cmd,
    output logic         busy,
    output logic         out_valid
);
    state_t state_reg, state_next;
    logic   axis_reg, axis_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        busy       = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    axis_next  = 1'b0;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                cmd.cordic_step = 1'b1;
                if (stat.cordic_done) state_next = ST_DEG;
            end
            ST_DEG: begin
                cmd.deg    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (!axis_reg) begin
                    axis_next  = 1'b1;
                    state_next = ST_PREP;
                end else begin
                    state_next = ST_GYRO;
                end
            end
            ST_GYRO: begin
                cmd.gyro   = 1'b1;
                state_next = ST_BLEND_MUL;
            end
            ST_BLEND_MUL: begin
                cmd.blend_mul = 1'b1;
                state_next    = ST_BLEND;
            end
            ST_BLEND: begin
                cmd.blend  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                cmd.out    = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                out_valid = 1'b1;
                if (out_fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== design/icaf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icaf_datapath
// CORDIC vectoring unit, reciprocal degree scaling, gyro integration, blend.
// ----------------------------------------------------------------------------
module icaf_datapath import icaf_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    input  wire in_item_t    in_item,
    input  wire logic [15:0] sample_interval,
    input  wire logic [15:0] acc_weight,
    input  wire logic [14:0] max_acc_norm,
    input  wire logic        invert_tilt_x,
    input  wire logic        invert_tilt_y,
    output status_t          stat,
    output out_item_t        out_item
);
    in_item_t              item_reg;
    logic signed [CW-1:0]  cx_reg, cy_reg;
    logic signed [ZW-1:0]  cz_reg;
    logic [StepW-1:0]      step_reg;
    logic                  zvec_reg;
    logic [31:0]           num_reg;   // (|z|*9000 + half) / 2^14, divided by 157 next
    logic                  neg_reg;
    logic signed [31:0]    tx_reg, ty_reg;
    logic signed [31:0]    ang_x_reg, ang_y_reg, ang_z_reg;
    logic signed [31:0]    zero_x_reg, zero_y_reg, zero_z_reg;
    logic signed [48:0]    bx_reg, by_reg;
    logic                  trust_reg;
    out_item_t             out_reg;

    // CORDIC input selection
    logic signed [15:0] vy, vx;
    assign vy = cmd.axis ? item_reg.accel_x : item_reg.accel_y;
    assign vx = item_reg.accel_z;

    logic signed [CW-1:0] sx, sy, xs, ys;
    always_comb begin
        sx = CW'(vx) <<< 14;
        sy = CW'(vy) <<< 14;
        xs = cx_reg >>> step_reg;
        ys = cy_reg >>> step_reg;
    end

    // gyro increments
    function automatic logic signed [47:0] gyro_inc(input logic signed [15:0] r,
                                                     input logic [15:0] dt);
        logic signed [47:0] p;
        begin
            p = 48'(r) * $signed({32'd0, dt});
            return (p + 48'sd64) >>> 7;
        end
    endfunction

    logic signed [31:0] gx, gy, gz;
    assign gx = sat32(48'(ang_x_reg) + gyro_inc(item_reg.rate_x, sample_interval));
    assign gy = sat32(48'(ang_y_reg) + gyro_inc(item_reg.rate_y, sample_interval));
    assign gz = sat32(48'(ang_z_reg) + gyro_inc(item_reg.rate_z, sample_interval));

    logic signed [31:0] sqx, sqy, sqz;
    logic [33:0] nsq;
    logic [29:0] lim;
    assign sqx = item_reg.accel_x * item_reg.accel_x;
    assign sqy = item_reg.accel_y * item_reg.accel_y;
    assign sqz = item_reg.accel_z * item_reg.accel_z;
    assign nsq = 34'(sqx) + 34'(sqy) + 34'(sqz);
    assign lim = max_acc_norm * max_acc_norm;

    logic signed [17:0] wa, wb;
    assign wa = $signed({2'b0, acc_weight});
    assign wb = 18'sd65536 - wa;

    logic signed [48:0] mx, my;
    assign mx = ang_x_reg * wb + tx_reg * wa + 49'sd32768;
    assign my = ang_y_reg * wb + ty_reg * wa + 49'sd32768;

    // divide by 157 as multiply by 2^32 + DEG_RECIP_LO, keep bits 40 and up
    logic [63:0] dlo;
    logic [65:0] dprod;
    logic [25:0] dq;
    logic signed [31:0] qs;
    assign dlo   = num_reg * DEG_RECIP_LO;
    assign dprod = {2'b00, dlo} + {2'b00, num_reg, 32'd0};
    assign dq    = dprod[65:40];
    assign qs    = neg_reg ? -$signed({6'd0, dq}) : $signed({6'd0, dq});

    assign stat.cordic_done = zvec_reg || (step_reg == StepW'(CordicSteps - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_x_reg  <= '0; ang_y_reg  <= '0; ang_z_reg  <= '0;
            zero_x_reg <= '0; zero_y_reg <= '0; zero_z_reg <= '0;
        end else begin
            if (cmd.load) item_reg <= in_item;
            if (cmd.prep) begin
                step_reg <= '0;
                zvec_reg <= (vx == 0) && (vy == 0);
                if (vx < 0) begin
                    cx_reg <= -sx; cy_reg <= -sy;
                    cz_reg <= (vy >= 0) ? PI_Q30 : -PI_Q30;
                end else begin
                    cx_reg <= sx; cy_reg <= sy; cz_reg <= '0;
                end
            end
            if (cmd.cordic_step && !zvec_reg) begin
                step_reg <= step_reg + 1'b1;
                if (cy_reg > 0) begin
                    cx_reg <= cx_reg + ys; cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + $signed(atan_tab(5'(step_reg)));
                end else begin
                    cx_reg <= cx_reg - ys; cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - $signed(atan_tab(5'(step_reg)));
                end
            end
            if (cmd.deg) begin
                neg_reg <= cz_reg < 0;
                num_reg <= zvec_reg ? 32'd0 :
                           32'((46'(cz_reg < 0 ? -cz_reg : cz_reg) * DEG_NUM
                                + DEG_HALF) >> 14);
            end
            if (cmd.div_step) begin
                if (cmd.axis) ty_reg <= invert_tilt_y ? -qs : qs;
                else          tx_reg <= invert_tilt_x ? -qs : qs;
            end
            if (cmd.gyro) begin
                ang_x_reg <= gx; ang_y_reg <= gy; ang_z_reg <= gz;
                trust_reg <= nsq < 34'(lim);
            end
            if (cmd.blend_mul) begin
                bx_reg <= mx;
                by_reg <= my;
            end
            if (cmd.blend && trust_reg) begin
                ang_x_reg <= sat32(48'(bx_reg >>> 16));
                ang_y_reg <= sat32(48'(by_reg >>> 16));
            end
            if (cmd.out) begin
                out_reg.pitch_deg <= sat32(48'(ang_x_reg) - 48'(zero_x_reg));
                out_reg.roll_deg  <= sat32(48'(ang_y_reg) - 48'(zero_y_reg));
                out_reg.yaw_deg   <= sat32(48'(ang_z_reg) - 48'(zero_z_reg));
                out_reg.accel_trusted <= trust_reg;
                if (item_reg.cmd) begin
                    zero_x_reg <= ang_x_reg;
                    zero_y_reg <= ang_y_reg;
                    zero_z_reg <= ang_z_reg;
                end
            end
        end
    end

    assign out_item = out_reg;
endmodule
`default_nettype wire

// ===== design/imu_complementary_angle_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an input transfer starts two CORDIC passes with degree scaling,
//   then gyro, blend, output; the passes dominate, ending early on a zero tilt vector.
// Flow: one item at a time; a new item is accepted only after m_data is
//   taken, and m_valid stays high while m_ready is low.
// Reset: aresetn synchronous active low; angles and zero points clear,
//   registers return to their defaults.
// ----------------------------------------------------------------------------
// imu_complementary_angle_filter_core
// Complementary attitude filter: gyro integration blended with accel tilt.
// ----------------------------------------------------------------------------
module imu_complementary_angle_filter_core import icaf_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire cfg_item_t cfg_data
);
    logic [15:0] interval_reg, weight_reg;
    logic [14:0] norm_reg;
    logic        inv_x_reg, inv_y_reg;

    // config writes always accepted
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= 16'd655;
            weight_reg   <= 16'd1311;
            norm_reg     <= 15'd3072;
            inv_x_reg    <= 1'b0;
            inv_y_reg    <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_data.index)
                REG_INTERVAL: interval_reg <= cfg_data.data[15:0];
                REG_WEIGHT:   weight_reg   <= cfg_data.data[15:0];
                REG_NORM:     norm_reg     <= cfg_data.data[14:0];
                REG_INV_X:    inv_x_reg    <= cfg_data.data[0];
                REG_INV_Y:    inv_y_reg    <= cfg_data.data[0];
                default: ;
            endcase
        end
    end

    cmd_t    cmd;
    status_t stat;
    logic    busy;

    assign s_ready = !busy;

    icaf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_valid && s_ready),
        .out_fire  (m_valid && m_ready),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (m_valid)
    );

    icaf_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .in_item         (s_data),
        .sample_interval (interval_reg),
        .acc_weight      (weight_reg),
        .max_acc_norm    (norm_reg),
        .invert_tilt_x   (inv_x_reg),
        .invert_tilt_y   (inv_y_reg),
        .stat            (stat),
        .out_item        (m_data)
    );
endmodule
`default_nettype wire
